### sv/bsec_pkg.sv
// Shared types, constants and helpers for the bit/symbol error counter.
package bsec_pkg;

    localparam int SYMBOL_WIDTH = 16;
    localparam int TOTAL_WIDTH  = 32;
    localparam int VALUE_WIDTH  = 16;
    localparam int GROUP_WIDTH  = 16;
    localparam int GERR_WIDTH   = 19;
    localparam int OUT_WIDTH    = 32;
    localparam int ERR_WIDTH    = 4;   // up to eight bit errors per word
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_IDX_WIDTH = 1;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ERROR_MODE      = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ITEMS_PER_GROUP = 1'd1;

    localparam logic                   MODE_SYMBOL   = 1'b0;
    localparam logic                   MODE_BIT      = 1'b1;
    localparam logic [GROUP_WIDTH-1:0] GROUP_RESET   = 16'd256;

    // classified word passed from the front end to the accumulators
    typedef struct packed {
        logic [ERR_WIDTH-1:0] err;
        logic                 last;
    } t_item;

    // limit a packet total to the 32-bit output field
    function automatic logic [OUT_WIDTH-1:0] clip_out(input logic [TOTAL_WIDTH-1:0] v);
        logic [48:0] wide;
        wide = 49'(v);
        if (wide > 49'h0_FFFF_FFFF) begin
            return {OUT_WIDTH{1'b1}};
        end
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage

### sv/bsec_front.sv
// Front end: takes a word pair and turns it into an error count.
module bsec_front
    import bsec_pkg::*;
(
    input  logic                   i_error_mode,
    input  logic [VALUE_WIDTH-1:0] i_tx_value,
    input  logic [VALUE_WIDTH-1:0] i_rx_value,
    input  logic                   i_last_item,
    output t_item                  o_item
);

    logic [7:0]           diff;
    logic [ERR_WIDTH-1:0] bit_errs;
    logic                 sym_err;

    always_comb begin
        diff     = i_tx_value[7:0] ^ i_rx_value[7:0];
        bit_errs = '0;
        for (int b = 0; b < 8; b++) begin
            bit_errs = bit_errs + ERR_WIDTH'(diff[b]);
        end
    end

    assign sym_err = (i_tx_value[SYMBOL_WIDTH-1:0] != i_rx_value[SYMBOL_WIDTH-1:0]);

    always_comb begin
        o_item.last = i_last_item;
        if (i_error_mode == MODE_BIT) begin
            o_item.err = bit_errs;
        end else begin
            o_item.err = ERR_WIDTH'(sym_err);
        end
    end

endmodule

### sv/bsec_fifo.sv
// Short queue between the front end and the accumulators.
module bsec_fifo
    import bsec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count,  n_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        QUEUE_AW'(r_wr_ptr - r_rd_ptr) == r_count[QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

### sv/bsec_back.sv
// Back end: group and packet accumulators with the report register.
module bsec_back
    import bsec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [GROUP_WIDTH-1:0] i_items_per_group,
    input  logic                   i_empty,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [GROUP_WIDTH-1:0] o_group_number,
    output logic [GERR_WIDTH-1:0]  o_group_errors,
    output logic [GROUP_WIDTH-1:0] o_group_items,
    output logic [OUT_WIDTH-1:0]   o_total_errors,
    output logic [OUT_WIDTH-1:0]   o_total_items,
    output logic                   o_packet_end
);

    logic [GROUP_WIDTH-1:0] r_pos,   n_pos;
    logic [GERR_WIDTH-1:0]  r_gerr,  n_gerr;
    logic [GROUP_WIDTH-1:0] r_gidx,  n_gidx;
    logic [TOTAL_WIDTH-1:0] r_terr,  n_terr;
    logic [TOTAL_WIDTH-1:0] r_titem, n_titem;
    logic                   r_out_valid;

    logic [GERR_WIDTH:0]    gerr_sum;
    logic [TOTAL_WIDTH:0]   terr_sum, titem_sum;
    logic [GERR_WIDTH-1:0]  gerr_upd;
    logic [GROUP_WIDTH-1:0] pos_upd;
    logic [TOTAL_WIDTH-1:0] terr_upd, titem_upd;
    logic [GROUP_WIDTH-1:0] limit;
    logic                   close;

    // report slot free, or being drained this cycle
    assign o_pop   = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;

    always_comb begin
        gerr_sum  = (GERR_WIDTH+1)'(r_gerr) + (GERR_WIDTH+1)'(i_item.err);
        gerr_upd  = gerr_sum[GERR_WIDTH] ? {GERR_WIDTH{1'b1}} : gerr_sum[GERR_WIDTH-1:0];
        pos_upd   = (r_pos == {GROUP_WIDTH{1'b1}}) ? r_pos : r_pos + 1'b1;
        terr_sum  = (TOTAL_WIDTH+1)'(r_terr) + (TOTAL_WIDTH+1)'(i_item.err);
        terr_upd  = terr_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : terr_sum[TOTAL_WIDTH-1:0];
        titem_sum = (TOTAL_WIDTH+1)'(r_titem) + (TOTAL_WIDTH+1)'(1'b1);
        titem_upd = titem_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : titem_sum[TOTAL_WIDTH-1:0];
        limit     = (i_items_per_group == '0) ? GROUP_WIDTH'(1) : i_items_per_group;
        close     = (pos_upd >= limit) || i_item.last;

        n_pos   = r_pos;
        n_gerr  = r_gerr;
        n_gidx  = r_gidx;
        n_terr  = r_terr;
        n_titem = r_titem;
        if (o_pop) begin
            if (i_item.last) begin
                n_pos   = '0;
                n_gerr  = '0;
                n_gidx  = '0;
                n_terr  = '0;
                n_titem = '0;
            end else if (close) begin
                n_pos   = '0;
                n_gerr  = '0;
                n_gidx  = (r_gidx == {GROUP_WIDTH{1'b1}}) ? r_gidx : r_gidx + 1'b1;
                n_terr  = terr_upd;
                n_titem = titem_upd;
            end else begin
                n_pos   = pos_upd;
                n_gerr  = gerr_upd;
                n_terr  = terr_upd;
                n_titem = titem_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_gerr      <= '0;
            r_gidx      <= '0;
            r_terr      <= '0;
            r_titem     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_gerr  <= n_gerr;
            r_gidx  <= n_gidx;
            r_terr  <= n_terr;
            r_titem <= n_titem;
            if (o_pop) begin
                r_out_valid <= close;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // report payload, loaded only when a word closes a group
    always_ff @(posedge i_clk) begin
        if (o_pop && close) begin
            o_group_number <= r_gidx;
            o_group_errors <= gerr_upd;
            o_group_items  <= pos_upd;
            o_total_errors <= clip_out(terr_upd);
            o_total_items  <= clip_out(titem_upd);
            o_packet_end   <= i_item.last;
        end
    end

    a_items_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_group_items != '0))
        else $error("report with empty group");

    a_totals_cover_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_total_items >= OUT_WIDTH'(o_group_items)))
        else $error("packet item total below group items");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.last) |=> (r_titem == '0 && r_gidx == '0 && r_out_valid))
        else $error("packet end did not clear counters");

    a_pos_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos < $past(limit)))
        else $error("open group reached its limit");

endmodule

### sv/bit_symbol_error_counter_top.sv
// Top level of the bit/symbol error counter: config registers and the three stages.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_stall    | i_tx_value, i_rx_value, i_last_item
//  output  | out       | o_valid / i_stall    | o_group_number .. o_packet_end
//  config  | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One word per clock is sustained while i_stall stays low; a report is presented once
// the word closing its group has passed into the four-entry queue and the accumulators
// have loaded the report register.
// Reset is synchronous and clears counters, queue and report valid; error_mode
// returns to bit mode and items_per_group to 256.
// A stalled report holds the accumulators; the queue takes up to four more
// words before o_stall rises.
module bit_symbol_error_counter_top
    import bsec_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]     i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [VALUE_WIDTH-1:0]   i_tx_value,
    input  logic [VALUE_WIDTH-1:0]   i_rx_value,
    input  logic                     i_last_item,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [GROUP_WIDTH-1:0]   o_group_number,
    output logic [GERR_WIDTH-1:0]    o_group_errors,
    output logic [GROUP_WIDTH-1:0]   o_group_items,
    output logic [OUT_WIDTH-1:0]     o_total_errors,
    output logic [OUT_WIDTH-1:0]     o_total_items,
    output logic                     o_packet_end
);

    logic                   r_error_mode;
    logic [GROUP_WIDTH-1:0] r_items_per_group;
    t_item                  front_item, queue_item;
    logic                   q_full, q_empty, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_mode      <= MODE_BIT;
            r_items_per_group <= GROUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ERROR_MODE:      r_error_mode      <= i_cfg_data[0];
                CFG_ITEMS_PER_GROUP: r_items_per_group <= i_cfg_data[GROUP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall = q_full;

    bsec_front u_front (
        .i_error_mode (r_error_mode),
        .i_tx_value   (i_tx_value),
        .i_rx_value   (i_rx_value),
        .i_last_item  (i_last_item),
        .o_item       (front_item)
    );

    bsec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (queue_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bsec_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_items_per_group (r_items_per_group),
        .i_empty           (q_empty),
        .i_item            (queue_item),
        .o_pop             (q_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_group_number    (o_group_number),
        .o_group_errors    (o_group_errors),
        .o_group_items     (o_group_items),
        .o_total_errors    (o_total_errors),
        .o_total_items     (o_total_items),
        .o_packet_end      (o_packet_end)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for the bit/symbol error counter: report scoreboard, drivers and checks.
module tb;
    import bsec_pkg::*;

    localparam logic [GERR_WIDTH-1:0] GROUP_ERR_MAX = {GERR_WIDTH{1'b1}};
    localparam int DRAIN_CYCLES = 10;      // queue depth plus the report register, with margin

    typedef struct {
        logic [GROUP_WIDTH-1:0] group_number;
        logic [GERR_WIDTH-1:0]  group_errors;
        logic [GROUP_WIDTH-1:0] group_items;
        logic [OUT_WIDTH-1:0]   total_errors;
        logic [OUT_WIDTH-1:0]   total_items;
        logic                   packet_end;
    } t_report;

    class error_report_board;
        logic                   mode;
        logic [GROUP_WIDTH-1:0] group_size;
        logic [GROUP_WIDTH-1:0] position;
        logic [GERR_WIDTH-1:0]  group_err_sum;
        logic [GROUP_WIDTH-1:0] group_idx;
        logic [TOTAL_WIDTH-1:0] packet_errs;
        logic [TOTAL_WIDTH-1:0] packet_words;
        t_report                pending_reports[$];
        int                     failures;
        int                     words_counted;
        int                     reports_checked;
        int                     packets_closed;

        function void clear_packet();
            position      = '0;
            group_err_sum = '0;
            group_idx     = '0;
            packet_errs   = '0;
            packet_words  = '0;
        endfunction

        function void reset_state();
            mode       = MODE_BIT;
            group_size = GROUP_RESET;
            clear_packet();
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
            if (idx == CFG_ERROR_MODE) begin
                mode = data[0];
            end else begin
                group_size = data[GROUP_WIDTH-1:0];
            end
        endfunction

        function logic [TOTAL_WIDTH-1:0] sat_total(logic [TOTAL_WIDTH-1:0] a,
                                                   logic [TOTAL_WIDTH-1:0] b);
            logic [TOTAL_WIDTH:0] s;
            s = a + b;
            return s[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : s[TOTAL_WIDTH-1:0];
        endfunction

        function logic [OUT_WIDTH-1:0] to_out(logic [TOTAL_WIDTH-1:0] v);
            logic [63:0] w;
            w = 64'(v);
            return ((w >> OUT_WIDTH) != 0) ? {OUT_WIDTH{1'b1}} : w[OUT_WIDTH-1:0];
        endfunction

        // predict the effect of one accepted word
        function void count_word(logic [VALUE_WIDTH-1:0] tx, logic [VALUE_WIDTH-1:0] rx,
                                 logic last);
            logic [ERR_WIDTH-1:0]   err;
            logic [GERR_WIDTH:0]    gsum;
            logic [GROUP_WIDTH-1:0] limit;
            t_report                r;
            words_counted++;
            if (mode == MODE_BIT) begin
                err = ERR_WIDTH'($countones(tx[7:0] ^ rx[7:0]));
            end else begin
                err = ERR_WIDTH'(tx[SYMBOL_WIDTH-1:0] != rx[SYMBOL_WIDTH-1:0]);
            end
            gsum = group_err_sum + err;
            group_err_sum = (gsum > GROUP_ERR_MAX) ? GROUP_ERR_MAX : gsum[GERR_WIDTH-1:0];
            if (position != {GROUP_WIDTH{1'b1}}) begin
                position++;
            end
            packet_errs  = sat_total(packet_errs, TOTAL_WIDTH'(err));
            packet_words = sat_total(packet_words, TOTAL_WIDTH'(1));
            limit = (group_size == '0) ? GROUP_WIDTH'(1) : group_size;
            if (position >= limit || last) begin
                r.group_number = group_idx;
                r.group_errors = group_err_sum;
                r.group_items  = position;
                r.total_errors = to_out(packet_errs);
                r.total_items  = to_out(packet_words);
                r.packet_end   = last;
                pending_reports.push_back(r);
                if (last) begin
                    clear_packet();
                end else begin
                    position      = '0;
                    group_err_sum = '0;
                    if (group_idx != {GROUP_WIDTH{1'b1}}) begin
                        group_idx++;
                    end
                end
            end
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                failures++;
                if (failures <= 40) begin
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, fname, want, seen);
                end
            end
        endfunction

        function void check_report(t_report got);
            t_report want;
            reports_checked++;
            if (pending_reports.size() == 0) begin
                failures++;
                $display("%0t: report with no word behind it, group_number %0d",
                         $time, got.group_number);
                return;
            end
            want = pending_reports.pop_front();
            if (want.packet_end) begin
                packets_closed++;
            end
            compare_field("group_number", want.group_number, got.group_number);
            compare_field("group_errors", want.group_errors, got.group_errors);
            compare_field("group_items",  want.group_items,  got.group_items);
            compare_field("total_errors", want.total_errors, got.total_errors);
            compare_field("total_items",  want.total_items,  got.total_items);
            compare_field("packet_end",   want.packet_end,   got.packet_end);
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_index;
    logic [CFG_WIDTH-1:0]     i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [VALUE_WIDTH-1:0]   i_tx_value;
    logic [VALUE_WIDTH-1:0]   i_rx_value;
    logic                     i_last_item;
    logic                     o_valid;
    logic                     i_stall;
    logic [GROUP_WIDTH-1:0]   o_group_number;
    logic [GERR_WIDTH-1:0]    o_group_errors;
    logic [GROUP_WIDTH-1:0]   o_group_items;
    logic [OUT_WIDTH-1:0]     o_total_errors;
    logic [OUT_WIDTH-1:0]     o_total_items;
    logic                     o_packet_end;

    error_report_board board;
    int tx_gap_max   = 9;
    int rx_stall_max = 9;

    bit_symbol_error_counter_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_tx_value     (i_tx_value),
        .i_rx_value     (i_rx_value),
        .i_last_item    (i_last_item),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_group_number (o_group_number),
        .o_group_errors (o_group_errors),
        .o_group_items  (o_group_items),
        .o_total_errors (o_total_errors),
        .o_total_items  (o_total_items),
        .o_packet_end   (o_packet_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

    // report side: random stall after each accepted report
    initial begin
        t_report got;
        int      hold;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.group_number = o_group_number;
                got.group_errors = o_group_errors;
                got.group_items  = o_group_items;
                got.total_errors = o_total_errors;
                got.total_items  = o_total_items;
                got.packet_end   = o_packet_end;
                board.check_report(got);
                hold = $urandom_range(rx_stall_max);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // valid is left high after acceptance; the next task decides whether it drops
    task automatic send_word(logic [VALUE_WIDTH-1:0] tx, logic [VALUE_WIDTH-1:0] rx,
                             logic last);
        int gap;
        gap = $urandom_range(tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_tx_value  <= tx;
        i_rx_value  <= rx;
        i_last_item <= last;
        do @(posedge i_clk); while (o_stall);
        board.count_word(tx, rx, last);
    endtask

    // hold the sender until every report is back and the queue has emptied
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (board.pending_reports.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic run_segment(int len);
        logic [VALUE_WIDTH-1:0] tx;
        logic [VALUE_WIDTH-1:0] rx;
        logic                   last;
        for (int n = 0; n < len; n++) begin
            tx = VALUE_WIDTH'($urandom);
            case ($urandom_range(3))
                0, 1:    rx = tx;
                2:       rx = tx ^ (VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1));
                default: rx = VALUE_WIDTH'($urandom);
            endcase
            last = ($urandom_range(24) == 0) || (n == len - 1 && $urandom_range(1) == 1);
            send_word(tx, rx, last);
        end
    endtask

    initial begin
        int                   random_sent;
        int                   len;
        int                   pick;
        logic [CFG_WIDTH-1:0] size;

        board = new;
        board.reset_state();
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_tx_value  <= '0;
        i_rx_value  <= '0;
        i_last_item <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ERROR_MODE;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, bit mode: full byte flips, upper-only flips
        send_word(16'h0000, 16'h0000, 1'b0);
        send_word(16'hFFFF, 16'h0000, 1'b0);
        send_word(16'h00FF, 16'hFF00, 1'b0);
        send_word(16'hFF00, 16'h0000, 1'b0);
        send_word(16'h0080, 16'h0001, 1'b0);
        send_word(16'h1234, 16'h1234, 1'b1);

        // zero group size behaves as one
        wait_idle();
        write_reg(CFG_ITEMS_PER_GROUP, 16'd0);
        send_word(16'h0055, 16'h00AA, 1'b0);
        send_word(16'hABCD, 16'hABCD, 1'b0);
        send_word(16'h0001, 16'h0000, 1'b1);

        // symbol mode, one word per group
        wait_idle();
        write_reg(CFG_ERROR_MODE, CFG_WIDTH'(MODE_SYMBOL));
        write_reg(CFG_ITEMS_PER_GROUP, 16'd1);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'h8000, 16'h0000, 1'b0);
        send_word(16'h0000, 16'h0001, 1'b1);

        // group size lowered while a group is open
        wait_idle();
        write_reg(CFG_ITEMS_PER_GROUP, 16'd4);
        send_word(16'h0003, 16'h0004, 1'b0);
        send_word(16'h0005, 16'h0005, 1'b0);
        wait_idle();
        write_reg(CFG_ITEMS_PER_GROUP, 16'd2);
        send_word(16'h7FFF, 16'hFFFF, 1'b0);
        send_word(16'h0000, 16'h0000, 1'b1);

        // mode switched part way through a packet
        wait_idle();
        write_reg(CFG_ITEMS_PER_GROUP, 16'd6);
        send_word(16'h0100, 16'h0000, 1'b0);
        send_word(16'h0200, 16'h0000, 1'b0);
        wait_idle();
        write_reg(CFG_ERROR_MODE, CFG_WIDTH'(MODE_BIT));
        send_word(16'h0100, 16'h0000, 1'b0);
        send_word(16'h000F, 16'h00F0, 1'b0);
        send_word(16'h0000, 16'h0000, 1'b0);
        send_word(16'h00FF, 16'h0000, 1'b0);
        send_word(16'h0001, 16'h0000, 1'b1);

        // largest group size, closed early by the final word
        wait_idle();
        write_reg(CFG_ITEMS_PER_GROUP, 16'hFFFF);
        send_word(16'h00C3, 16'h003C, 1'b0);
        send_word(16'h1111, 16'h2222, 1'b1);

        random_sent = 0;
        while (random_sent < 700) begin
            wait_idle();
            write_reg(CFG_ERROR_MODE, CFG_WIDTH'($urandom_range(1)));
            pick = $urandom_range(19);
            if (pick < 13) begin
                size = CFG_WIDTH'($urandom_range(12, 1));
            end else if (pick < 16) begin
                size = CFG_WIDTH'($urandom_range(300, 13));
            end else if (pick < 18) begin
                size = '0;
            end else begin
                size = 16'hFFFF;
            end
            write_reg(CFG_ITEMS_PER_GROUP, size);
            tx_gap_max   = ($urandom_range(3) == 0) ? 0 : 9;
            rx_stall_max = ($urandom_range(3) == 0) ? 0 : 9;
            len = $urandom_range(60, 15);
            run_segment(len);
            random_sent += len;
        end

        wait_idle();
        if (board.pending_reports.size() != 0) begin
            board.failures++;
            $display("%0t: %0d expected reports never arrived",
                     $time, board.pending_reports.size());
        end
        $display("Covered %0d words and %0d reports over %0d packets in bit and symbol mode,",
                 board.words_counted, board.reports_checked, board.packets_closed);
        $display("group sizes 0 to 65535, full-rate and stalled traffic, mid-packet changes.");
        if (board.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
